[hw/rtl/bu2x_pkg.sv]
// Shared types and constants of the 2x bilinear upscaler.
package bu2x_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'd1;

  // Output row group of one source pixel's results
  typedef enum logic [1:0] {
    PH_ODD,
    PH_EVEN,
    PH_LAST
  } phase_t;

  // One source pixel's worth of results, handed to the result sequencer
  typedef struct packed {
    logic                          has_p0;    // pair left of the pixel
    logic                          has_p1;    // edge pair at the pixel
    logic                          has_odd;   // row above is emitted
    logic                          has_last;  // bottom repeat row is emitted
    logic                          frame;     // final pixel of the plane
    logic [COORD_W-1:0]            col_base;
    logic [COORD_W-1:0]            row_even;
    logic [COORD_W-1:0]            row_last;
    logic [3:0][PIX_W-1:0]         ev;
    logic [3:0][PIX_W-1:0]         od;
  } job_t;

endpackage

[hw/rtl/bu2x_pix_if.sv]
// Source pixel channel.
interface bu2x_pix_if import bu2x_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

[hw/rtl/bu2x_res_if.sv]
// Result pixel channel.
interface bu2x_res_if import bu2x_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic [PIX_W-1:0]   value;
  logic               run_end;
  logic               frame_end;

  modport source (output valid, output out_col, output out_row, output value,
                  output run_end, output frame_end, input ready);
  modport sink   (input valid, input out_col, input out_row, input value,
                  input run_end, input frame_end, output ready);
endinterface

[hw/rtl/bu2x_linebuf.sv]
// Line buffer: single-port memory with read-before-write.
module bu2x_linebuf import bu2x_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  // Old entry comes out while the new pixel goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

[hw/rtl/bu2x_emit.sv]
// Result sequencer: walks one pixel's results into the output register.
module bu2x_emit import bu2x_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              ld_valid,
  output logic              ld_ready,
  input  job_t              ld_job,
  bu2x_res_if.source        res
);

  job_t   job;
  logic   job_valid, job_valid_next;
  phase_t phase, phase_next;
  logic [1:0] k, k_next;
  logic [1:0] k_stop, k_first;
  phase_t ph_stop;
  logic   last_one, emit;
  logic   out_valid;
  logic [COORD_W-1:0] row_sel;
  logic [PIX_W-1:0]   val_sel;

  always_comb begin
    k_stop   = job.has_p1 ? 2'd3 : 2'd1;
    k_first  = job.has_p0 ? 2'd0 : 2'd2;
    ph_stop  = job.has_last ? PH_LAST : PH_EVEN;
    last_one = (k == k_stop) && (phase == ph_stop);
    emit     = job_valid && (!out_valid || res.ready);
    ld_ready = !job_valid || (emit && last_one);

    job_valid_next = job_valid;
    phase_next     = phase;
    k_next         = k;
    if (ld_valid && ld_ready) begin
      job_valid_next = 1'b1;
      k_next         = ld_job.has_p0 ? 2'd0 : 2'd2;
      phase_next     = ld_job.has_odd ? PH_ODD : PH_EVEN;
    end else if (emit) begin
      if (last_one) begin
        job_valid_next = 1'b0;
      end else if (k == k_stop) begin
        k_next     = k_first;
        phase_next = (phase == PH_ODD) ? PH_EVEN : PH_LAST;
      end else begin
        k_next = k + 2'd1;
      end
    end

    unique case (phase)
      PH_ODD: begin
        row_sel = job.row_even - 12'd1;
        val_sel = job.od[k];
      end
      PH_EVEN: begin
        row_sel = job.row_even;
        val_sel = job.ev[k];
      end
      PH_LAST: begin
        row_sel = job.row_last;
        val_sel = job.ev[k];
      end
      default: begin
        row_sel = job.row_even;
        val_sel = job.ev[k];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase     <= PH_EVEN;
      k         <= 2'd0;
    end else begin
      job_valid <= job_valid_next;
      phase     <= phase_next;
      k         <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      job <= ld_job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.out_col   <= job.col_base + {10'd0, k};
      res.out_row   <= row_sel;
      res.value     <= val_sel;
      res.run_end   <= last_one;
      res.frame_end <= last_one && job.frame;
    end
  end

  assign res.valid = out_valid;

endmodule

[hw/rtl/bilinear_upscale_2x_core.sv]
// Top level of the 2x bilinear upscaler.
//
// Source pixels enter on the pix channel in raster order, one per transfer.
// Results leave on the res channel, each tagged with its column and row in
// the doubled plane; run_end marks the last result of a source pixel and
// frame_end the final pixel of the plane. A pixel in column 0 of a plane
// wider than one pixel makes no results; others make 2 to 12.
// A pixel's results pass the lookup stage and the sequencer's job register,
// then leave from the output register. res carries one result per cycle
// while res.ready is high, four per pixel on average; that output port sets
// the rate. A new pixel waits in the lookup stage while earlier results drain.
// The one-row line buffer is a single-port memory read and written in the
// same cycle, old value out, new value in.
// Reset (rst, synchronous) loads width 768 and height 512 and starts a frame.
// A configuration write also starts a new frame; write only when idle.
// When res stalls, results hold in the output register, the sequencer and
// the lookup stage fill, then pix.ready drops.
module bilinear_upscale_2x_core import bu2x_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  bu2x_pix_if.sink             pix,
  bu2x_res_if.source           res,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [XW-1:0] X_TOP = XW'(MAX_WIDTH - 1);
  localparam logic [YW-1:0] Y_TOP = YW'(MAX_HEIGHT - 1);

  // Configuration
  logic [CFG_W-1:0] src_width, src_height;
  logic [XW-1:0]    w_last;
  logic [YW-1:0]    h_last;

  // Front stage: position counters
  logic [XW-1:0] col_count;
  logic [YW-1:0] row_count;
  logic          last_col, last_row;
  logic          accept;

  // Lookup stage: pixel waits here for its line buffer read
  logic             s1_valid;
  logic [PIX_W-1:0] s1_c;
  logic [XW-1:0]    s1_x;
  logic [YW-1:0]    s1_y;
  logic             s1_lc, s1_lr;
  logic             s1_move, s1_none;
  logic [PIX_W-1:0] upper;
  logic [PIX_W-1:0] left_pixel, upper_left_pixel;

  job_t job;
  logic job_ready;

  logic [PIX_W:0]   sum_ll, sum_lc, sum_uc;
  logic [PIX_W+1:0] sum4;

  // Clamp the sizes; zero acts as one
  always_comb begin
    if (src_width == '0) begin
      w_last = '0;
    end else if (32'(src_width) > 32'(MAX_WIDTH)) begin
      w_last = X_TOP;
    end else begin
      w_last = XW'(src_width - 12'd1);
    end
    if (src_height == '0) begin
      h_last = '0;
    end else if (32'(src_height) > 32'(MAX_HEIGHT)) begin
      h_last = Y_TOP;
    end else begin
      h_last = YW'(src_height - 12'd1);
    end
  end

  assign last_col  = (col_count == w_last);
  assign last_row  = (row_count == h_last);
  assign accept    = pix.valid && pix.ready;
  assign pix.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= CFG_W'(768);
      src_height <= CFG_W'(512);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data;
        CFG_SRC_HEIGHT: src_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the raster position; any configuration write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + YW'(1);
      end else begin
        col_count <= col_count + XW'(1);
      end
    end
  end

  bu2x_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_linebuf (
    .clk   (clk),
    .en    (accept),
    .addr  (col_count),
    .wdata (pix.pixel),
    .rdata (upper)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c  <= pix.pixel;
      s1_x  <= col_count;
      s1_y  <= row_count;
      s1_lc <= last_col;
      s1_lr <= last_row;
    end
  end

  // Neighbors of the next pixel; cleared at the start of a frame
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (s1_move) begin
      left_pixel       <= s1_c;
      upper_left_pixel <= upper;
    end
  end

  // Pixel in the first column of a wider plane waits for its right neighbor
  assign s1_none = (s1_x == '0) && !s1_lc;
  assign s1_move = s1_valid && (s1_none || job_ready);

  // Rounded averages
  assign sum_ll = {1'b0, upper_left_pixel} + {1'b0, left_pixel} + 9'd1;
  assign sum_lc = {1'b0, left_pixel} + {1'b0, s1_c} + 9'd1;
  assign sum_uc = {1'b0, upper} + {1'b0, s1_c} + 9'd1;
  assign sum4   = {2'b0, upper_left_pixel} + {2'b0, upper} + {2'b0, left_pixel}
                + {2'b0, s1_c} + 10'd2;

  always_comb begin
    job.has_p0   = (s1_x != '0);
    job.has_p1   = s1_lc;
    job.has_odd  = (s1_y != '0);
    job.has_last = s1_lr;
    job.frame    = s1_lc && s1_lr;
    job.col_base = (COORD_W'(s1_x) << 1) - 12'd2;
    job.row_even = COORD_W'(s1_y) << 1;
    job.row_last = (COORD_W'(h_last) << 1) + 12'd1;
    job.ev[0]    = left_pixel;
    job.od[0]    = sum_ll[PIX_W:1];
    job.ev[1]    = sum_lc[PIX_W:1];
    job.od[1]    = sum4[PIX_W+1:2];
    job.ev[2]    = s1_c;
    job.od[2]    = sum_uc[PIX_W:1];
    job.ev[3]    = s1_c;
    job.od[3]    = sum_uc[PIX_W:1];
  end

  bu2x_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .ld_valid (s1_valid && !s1_none),
    .ld_ready (job_ready),
    .ld_job   (job),
    .res      (res)
  );

endmodule

[tb/sv/tb_bilinear_upscale_2x_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the 2x bilinear upscaler core, with a predicting scoreboard.
module tb_bilinear_upscale_2x_core;
  import bu2x_pkg::*;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  // Give the pipe room to empty after the last due result.
  localparam int SETTLE_CYCLES = 8;
  // Source pixels sent in the random phases, and in each cut-off run at the
  // largest sizes.
  localparam int RANDOM_ITEMS = 75;
  localparam int EDGE_ITEMS   = 6;
  // Slowest correct run: about 120 pixels, each at worst 12 results that wait
  // out the longest sink stall, plus the longest gap on the source side.
  // Allow several times that.
  localparam longint TIMEOUT_NS = 1_000_000;

  // One pixel of the doubled plane as it leaves on the result channel.
  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [PIX_W-1:0]   value;
    logic               run_end;
    logic               frame_end;
  } out_pix_t;

  // Tracks sizes, line buffer and neighbors the way the core should, and
  // holds the output pixels each accepted source pixel is due to produce.
  class upscale_board;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] line_buf [MAX_W];
    logic [PIX_W-1:0] left_px;
    logic [PIX_W-1:0] upper_left_px;
    int unsigned      col_at;
    int unsigned      row_at;
    out_pix_t         due_pixels[$];
    int unsigned      errors;

    function new();
      width_reg  = 12'd768;
      height_reg = 12'd512;
      foreach (line_buf[i]) line_buf[i] = '0;
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      left_px       = '0;
      upper_left_px = '0;
      col_at        = 0;
      row_at        = 0;
    endfunction

    // A size of zero acts as one; anything past the maximum is clipped.
    function int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
    endfunction

    function int unsigned pending();
      return due_pixels.size();
    endfunction

    // Any register write starts a new frame.
    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SRC_WIDTH:  width_reg  = val;
        CFG_SRC_HEIGHT: height_reg = val;
        default: ;
      endcase
      restart_frame();
    endfunction

    // Work out the output pixels that source pixel c completes, then advance.
    function void take_source_pixel(logic [PIX_W-1:0] c);
      int unsigned w, h, x, y, u, l, ul, side_avg, m, nr, r, k;
      int unsigned ev[4], od[4], ec[4], rows[3];
      bit          odd_row[3];
      bit          last_col, last_row;
      out_pix_t    p;
      w  = eff_size(width_reg, MAX_W);
      h  = eff_size(height_reg, MAX_H);
      x  = col_at;
      y  = row_at;
      if (x >= w) x = w - 1;
      if (y >= h) y = h - 1;
      u  = line_buf[x];
      l  = left_px;
      ul = upper_left_px;
      last_col = (x == w - 1);
      last_row = (y == h - 1);
      m = 0;
      if (x >= 1) begin
        ec[m] = 2 * x - 2; ev[m] = l;               od[m] = (ul + l + 1) >> 1;         m++;
        ec[m] = 2 * x - 1; ev[m] = (l + c + 1) >> 1; od[m] = (ul + u + l + c + 2) >> 2; m++;
      end
      if (last_col) begin
        side_avg = (u + c + 1) >> 1;
        ec[m] = 2 * x;     ev[m] = c; od[m] = side_avg; m++;
        ec[m] = 2 * x + 1; ev[m] = c; od[m] = side_avg; m++;
      end
      nr = 0;
      if (y >= 1) begin
        rows[nr] = 2 * y - 1; odd_row[nr] = 1'b1; nr++;
      end
      rows[nr] = 2 * y; odd_row[nr] = 1'b0; nr++;
      if (last_row) begin
        rows[nr] = 2 * h - 1; odd_row[nr] = 1'b0; nr++;
      end
      for (r = 0; r < nr; r++) begin
        for (k = 0; k < m; k++) begin
          p.out_col   = COORD_W'(ec[k]);
          p.out_row   = COORD_W'(rows[r]);
          p.value     = odd_row[r] ? PIX_W'(od[k]) : PIX_W'(ev[k]);
          p.run_end   = (r == nr - 1) && (k == m - 1);
          p.frame_end = p.run_end && last_col && last_row;
          due_pixels.push_back(p);
        end
      end
      line_buf[x]   = c;
      left_px       = c;
      upper_left_px = PIX_W'(u);
      if (last_col) begin
        col_at = 0;
        row_at = last_row ? 0 : y + 1;
      end else begin
        col_at = x + 1;
        row_at = y;
      end
    endfunction

    function void match_output_pixel(out_pix_t got);
      out_pix_t want;
      if (due_pixels.size() == 0) begin
        $error("unexpected result: out_col %0d out_row %0d value %0d",
               got.out_col, got.out_row, got.value);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        errors++;
      end
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  bit                   src_calm;   // source sends back to back while set
  bit                   sink_calm;  // sink takes every result while set
  upscale_board         board;
  logic [PIX_W-1:0]     burst_q[$];

  bu2x_pix_if pix_ch ();
  bu2x_res_if res_ch ();

  bilinear_upscale_2x_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix_ch.sink),
    .res       (res_ch.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the core hangs or loses results.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL bilinear_upscale_2x_core");
    $finish;
  end

  // Mostly random pixels, with the extremes showing up often.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Small sizes so frames stay short; now and then zero, which acts as one.
  function automatic logic [CFG_W-1:0] pick_size(int unsigned limit);
    if ($urandom_range(0, 7) == 0) return '0;
    return CFG_W'($urandom_range(1, limit));
  endfunction

  // Offer one source pixel after a random gap and hold it until the transfer.
  // Valid stays high on return so a zero gap keeps the stream back to back.
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= v;
    do @(posedge clk); while (!pix_ch.ready);
    board.take_source_pixel(v);
  endtask

  task automatic send_queue();
    foreach (burst_q[i]) send_pixel(burst_q[i]);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(pick_pixel());
  endtask

  // Drop valid, wait for every due result, then let the pipe empty: a pixel
  // that makes no results may still be in flight when the last one lands.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one or both size registers; enable drops once, after the last write.
  task automatic configure(input bit do_w, input bit do_h,
                           input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    if (do_w) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_SRC_WIDTH;
      cfg_data  <= w;
      @(posedge clk);
      board.note_config(CFG_SRC_WIDTH, w);
    end
    if (do_h) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_SRC_HEIGHT;
      cfg_data  <= h;
      @(posedge clk);
      board.note_config(CFG_SRC_HEIGHT, h);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Start a frame at the given sizes and send the first n pixels of it, with
  // fresh idling choices.
  task automatic run_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int unsigned n);
    configure(1'b1, 1'b1, w, h);
    src_calm  = ($urandom_range(0, 3) == 0);
    sink_calm = ($urandom_range(0, 3) == 0);
    send_random(n);
    settle();
  endtask

  // Result side: stall a random number of cycles before each transfer, then
  // check the transferred pixel against the oldest one due.
  task automatic drain_results();
    int unsigned gap;
    out_pix_t    got;
    forever begin
      gap = sink_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.out_col   = res_ch.out_col;
      got.out_row   = res_ch.out_row;
      got.value     = res_ch.value;
      got.run_end   = res_ch.run_end;
      got.frame_end = res_ch.frame_end;
      board.match_output_pixel(got);
    end
  endtask

  initial begin
    int unsigned fed, count, fp;
    bit          do_w, do_h;
    board = new();
    // Drive every input to a known value before the first edge.
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_SRC_WIDTH;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    src_calm     = 1'b0;
    sink_calm    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // Reset sizes (768 x 512): the first column makes nothing, later ones a
    // pair on output row 0.
    burst_q = '{8'd0, 8'd255, 8'd128};
    send_queue();
    settle();

    // One-pixel plane, two frames back to back: every pixel ends a frame.
    configure(1'b1, 1'b1, 12'd1, 12'd1);
    burst_q = '{8'd255, 8'd0};
    send_queue();
    settle();

    // Zero sizes act as one.
    configure(1'b1, 1'b1, 12'd0, 12'd0);
    burst_q = '{8'd255};
    send_queue();
    settle();

    // 2 x 2: the last pixel completes the full dozen results.
    configure(1'b1, 1'b1, 12'd2, 12'd2);
    burst_q = '{8'd255, 8'd0, 8'd0, 8'd255};
    send_queue();
    settle();

    // 3 x 2 with odd sums for rounding, then wrap into the next frame.
    configure(1'b1, 1'b1, 12'd3, 12'd2);
    burst_q = '{8'd255, 8'd254, 8'd1, 8'd0, 8'd254, 8'd255, 8'd7, 8'd200};
    send_queue();
    settle();

    // Height alone, written mid-frame: the frame restarts at the top left.
    configure(1'b0, 1'b1, 12'd3, 12'd3);
    burst_q = '{8'd128, 8'd127, 8'd1};
    send_queue();
    settle();

    // Random phases: whole frames with random content, sometimes followed by
    // a cut-off frame that the next register write abandons.
    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      do_w = $urandom_range(0, 1);
      do_h = !do_w || ($urandom_range(0, 1) == 1);
      configure(do_w, do_h, pick_size(6), pick_size(5));
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      fp    = board.frame_pixels();
      count = $urandom_range(1, 2) * fp;
      if ($urandom_range(0, 2) == 0) count += $urandom_range(0, fp - 1);
      if (count > RANDOM_ITEMS - fed) count = RANDOM_ITEMS - fed;
      send_random(count);
      fed += count;
      settle();
    end

    // Largest sizes, each kept thin in the other direction; past the maximum
    // a size is clipped to it. Send only the start of each frame.
    run_frame(12'd4095, 12'd1, EDGE_ITEMS);
    run_frame(12'd1, 12'd4095, EDGE_ITEMS);
    run_frame(12'd2048, 12'd1, EDGE_ITEMS);
    run_frame(12'd1, 12'd2048, EDGE_ITEMS);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS bilinear_upscale_2x_core");
    end else begin
      $display("FAIL bilinear_upscale_2x_core");
    end
    $finish;
  end

endmodule
